### rtl/rlfd_pkg.sv
`default_nettype none

package rlfd_pkg;

    localparam int unsigned NUM_CH      = 3;
    localparam int unsigned LEVEL_W     = 16;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PERIOD_W    = 16;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned S_TDATA_W   = 32;
    localparam int unsigned S_TUSER_W   = 2;
    localparam int unsigned M_TDATA_W   = 80;
    localparam int unsigned SCALE_SHIFT = 7 + 8;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd512;
    localparam logic [BYTE_W-1:0]   MULT_DEFAULT = 8'hff;

    typedef enum logic [1:0] {
        OP_ANIMATE = 2'd0,
        OP_TICK    = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PWM_PERIOD  = 3'd0,
        REG_ACTIVE_HIGH = 3'd1,
        REG_MULT_RED    = 3'd2,
        REG_MULT_GREEN  = 3'd3,
        REG_MULT_BLUE   = 3'd4,
        REG_MONO_MODE   = 3'd5
    } reg_idx_t;

    localparam logic KIND_DRIVE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

endpackage

`default_nettype wire

### rtl/rgb_led_fade_pwm_driver_top.sv
// a result is registered and presented in the cycle after the transaction that causes it
// throughput: one input transaction per cycle; tick, fade and duty math run in a
// single registered pass, held back only while an unaccepted result waits
// reset: synchronous active-low aresetn clears levels, steps, targets and the
// output valid, and loads defaults (period 512, active high, mults 255, mono off)
`default_nettype none

module rgb_led_fade_pwm_driver_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // to_red, to_green, to_blue, fade_speed
    input  wire logic [rlfd_pkg::S_TDATA_W-1:0]      s_tdata,
    // operation
    input  wire logic [rlfd_pkg::S_TUSER_W-1:0]      s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // duty_red, duty_green, duty_blue, enable_red, enable_green, enable_blue,
    // power_request, color_red, color_green, color_blue, zero pad
    output logic [rlfd_pkg::M_TDATA_W-1:0]           m_tdata,
    // kind
    output logic                                     m_tuser,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rlfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rlfd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned N = rlfd_pkg::NUM_CH;

    // configuration
    logic [rlfd_pkg::PERIOD_W-1:0] period_reg;
    logic                          active_high_reg;
    logic [7:0]                    mult_reg [N];
    logic                          mono_reg;

    // fade state
    logic [15:0]        level_reg  [N];
    logic signed [15:0] step_reg   [N];
    logic [7:0]         target_reg [N];

    // output register
    logic                               m_tvalid_reg;
    logic [rlfd_pkg::M_TDATA_W-1:0]     m_tdata_reg;
    logic                               m_tuser_reg;

    // combinational
    logic               s_fire;
    logic [7:0]         to_byte   [N];
    logic [7:0]         speed;
    logic signed [15:0] step_anim [N];
    logic [15:0]        level_tick [N];
    logic signed [15:0] step_tick [N];
    logic               changed;
    logic [17:0]        mono_sum;
    logic [15:0]        drive_lv  [N];
    logic [8:0]         scaled    [N];
    logic [15:0]        duty      [N];
    logic               enable    [N];
    logic               power_req;
    logic [rlfd_pkg::M_TDATA_W-1:0] drive_data;
    logic [rlfd_pkg::M_TDATA_W-1:0] read_data;

    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign to_byte[0] = s_tdata[7:0];
    assign to_byte[1] = s_tdata[15:8];
    assign to_byte[2] = s_tdata[23:16];
    assign speed      = s_tdata[31:24];

    // animate step and tick update per channel
    always_comb begin
        logic signed [8:0]  diff;
        logic signed [17:0] prod;
        logic signed [17:0] v;
        logic [8:0]         v_hi;
        logic               snap;
        diff    = '0;
        prod    = '0;
        v       = '0;
        v_hi    = '0;
        snap    = 1'b0;
        changed = 1'b0;
        for (int i = 0; i < N; i++) begin
            diff = $signed({1'b0, to_byte[i]}) - $signed({1'b0, level_reg[i][15:8]});
            prod = 18'(diff) * $signed({10'b0, speed});
            step_anim[i] = prod[16:1];

            v    = $signed({2'b00, level_reg[i]}) + 18'(step_reg[i]);
            v_hi = v[16:8];
            snap = (step_reg[i] == 16'sd0)
                || (step_reg[i] < 16'sd0 && (v[17] || v_hi < {1'b0, target_reg[i]}))
                || (step_reg[i] > 16'sd0 && v_hi > {1'b0, target_reg[i]});
            level_tick[i] = snap ? {target_reg[i], 8'h00} : v[15:0];
            step_tick[i]  = snap ? 16'sd0 : step_reg[i];
            if (level_tick[i] != level_reg[i]) begin
                changed = 1'b1;
            end
        end
    end

    assign mono_sum = {2'b00, level_tick[0]} + {1'b0, level_tick[1], 1'b0}
                    + {2'b00, level_tick[2]};

    // mono mixing, scaling and polarity per channel
    always_comb begin
        logic [23:0] prod;
        logic [16:0] inv;
        prod = '0;
        inv  = '0;
        for (int i = 0; i < N; i++) begin
            if (mono_reg) begin
                drive_lv[i] = (i == 0) ? mono_sum[17:2] : 16'd0;
            end else begin
                drive_lv[i] = level_tick[i];
            end
            prod      = {8'b0, drive_lv[i]} * {16'b0, mult_reg[i]};
            scaled[i] = prod[23:rlfd_pkg::SCALE_SHIFT];
            enable[i] = scaled[i] != 9'd0;
            inv       = {1'b0, period_reg} - {8'b0, scaled[i]};
            if (!enable[i]) begin
                duty[i] = 16'd0;
            end else if (active_high_reg) begin
                duty[i] = ({7'b0, scaled[i]} >= period_reg) ? period_reg - 16'd1
                                                            : {7'b0, scaled[i]};
            end else begin
                duty[i] = inv[16] ? 16'd0 : inv[15:0];
            end
        end
    end

    assign power_req  = enable[0] || enable[1] || enable[2];
    assign drive_data = {4'b0, 24'b0, power_req, enable[2], enable[1], enable[0],
                         duty[2], duty[1], duty[0]};
    assign read_data  = {4'b0, level_reg[2][15:8], level_reg[1][15:8],
                         level_reg[0][15:8], 4'b0, 48'b0};

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg      <= rlfd_pkg::PERIOD_MIN;
            active_high_reg <= 1'b1;
            mono_reg        <= 1'b0;
            for (int i = 0; i < N; i++) begin
                mult_reg[i] <= rlfd_pkg::MULT_DEFAULT;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                rlfd_pkg::REG_PWM_PERIOD: begin
                    period_reg <= (cfg_data < rlfd_pkg::PERIOD_MIN) ? rlfd_pkg::PERIOD_MIN
                                                                    : cfg_data;
                end
                rlfd_pkg::REG_ACTIVE_HIGH: active_high_reg <= cfg_data[0];
                rlfd_pkg::REG_MULT_RED: begin
                    mult_reg[0] <= (cfg_data[7:0] == 8'd0) ? rlfd_pkg::MULT_DEFAULT
                                                           : cfg_data[7:0];
                end
                rlfd_pkg::REG_MULT_GREEN: begin
                    mult_reg[1] <= (cfg_data[7:0] == 8'd0) ? rlfd_pkg::MULT_DEFAULT
                                                           : cfg_data[7:0];
                end
                rlfd_pkg::REG_MULT_BLUE: begin
                    mult_reg[2] <= (cfg_data[7:0] == 8'd0) ? rlfd_pkg::MULT_DEFAULT
                                                           : cfg_data[7:0];
                end
                rlfd_pkg::REG_MONO_MODE: mono_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // fade state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < N; i++) begin
                level_reg[i]  <= '0;
                step_reg[i]   <= '0;
                target_reg[i] <= '0;
            end
        end else begin
            if (s_fire && (s_tuser == rlfd_pkg::OP_READ
                           || (s_tuser == rlfd_pkg::OP_TICK && changed))) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (s_fire) begin
                case (s_tuser)
                    rlfd_pkg::OP_ANIMATE: begin
                        for (int i = 0; i < N; i++) begin
                            step_reg[i]   <= step_anim[i];
                            target_reg[i] <= to_byte[i];
                        end
                    end
                    rlfd_pkg::OP_TICK: begin
                        for (int i = 0; i < N; i++) begin
                            level_reg[i] <= level_tick[i];
                            step_reg[i]  <= step_tick[i];
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_fire && s_tuser == rlfd_pkg::OP_TICK && changed) begin
            m_tdata_reg <= drive_data;
            m_tuser_reg <= rlfd_pkg::KIND_DRIVE;
        end else if (s_fire && s_tuser == rlfd_pkg::OP_READ) begin
            m_tdata_reg <= read_data;
            m_tuser_reg <= rlfd_pkg::KIND_READ;
        end
    end

    // checks
    a_read_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser == rlfd_pkg::OP_READ
        |=> m_tvalid && m_tuser == rlfd_pkg::KIND_READ)
        else $error("read transaction gave no readback");

    a_read_no_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rlfd_pkg::KIND_READ |-> m_tdata[51:0] == 52'd0)
        else $error("readback carries drive fields");

    a_enable_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rlfd_pkg::KIND_DRIVE
        |-> m_tdata[48] == (m_tdata[15:0] != 16'd0)
         && m_tdata[49] == (m_tdata[31:16] != 16'd0)
         && m_tdata[50] == (m_tdata[47:32] != 16'd0))
        else $error("enable disagrees with duty");

    a_power_req: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == rlfd_pkg::KIND_DRIVE
        |-> m_tdata[51] == (m_tdata[48] || m_tdata[49] || m_tdata[50]))
        else $error("power request disagrees with enables");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire
